// ----- rtl/fir_full_convolution_defines.svh -----
// ----------------------------------------------------------------------------
// fir_full_convolution_defines : assertion macros
// Shared property wrappers for the checker of the convolution block.
// ----------------------------------------------------------------------------
`ifndef FIR_FULL_CONVOLUTION_DEFINES_SVH
`define FIR_FULL_CONVOLUTION_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define FCV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define FCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fcv_pkg.sv -----
// ----------------------------------------------------------------------------
// fcv_pkg : shared definitions of the FIR full convolution block
// Widths, derived sizes, request and result types, and control codes.
// ----------------------------------------------------------------------------
package fcv_pkg;

  localparam int MAX_TAPS  = 8;
  localparam int VALUE_W   = 16;
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int RESULT_W  = 35;
  localparam int TAPCFG_W  = 4;
  localparam int IDX_W     = 3;

  // Width that holds a tap count from 1 to MAX_TAPS and the raw register.
  localparam int CNT_W = ($clog2(MAX_TAPS + 1) > TAPCFG_W) ? $clog2(MAX_TAPS + 1) : TAPCFG_W;
  // Width for comparing a load index against a cell position.
  localparam int SEL_W = ($clog2(MAX_TAPS) > IDX_W) ? $clog2(MAX_TAPS) : IDX_W;

  // Registered adder tree.
  localparam int LEVELS = $clog2(MAX_TAPS);
  localparam int LEAVES = 1 << LEVELS;

  // Result queue: deep enough to cover every result in flight.
  localparam int QUEUE_DEPTH = 1 << $clog2(LEVELS + 3);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [TAPCFG_W-1:0] TAP_COUNT_RESET = TAPCFG_W'(8);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       operation;
    logic [IDX_W-1:0]           tap_index;
    logic signed [VALUE_W-1:0]  value;
    logic                       last_sample;
  } item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic                       last_of_run;
  } res_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

endpackage

// ----- rtl/fcv_tap_cell.sv -----
// ----------------------------------------------------------------------------
// fcv_tap_cell : one tap of the delay line
// Holds one sample and one coefficient and registers their masked product.
// ----------------------------------------------------------------------------
module fcv_tap_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  fcv_pkg::cell_ctrl_t               ctrl,
  input  logic                              kernel_we,
  input  logic [fcv_pkg::VALUE_W-1:0]       kernel_data,
  input  logic                              tap_on,
  input  logic [fcv_pkg::VALUE_W-1:0]       sample_in,
  output logic [fcv_pkg::VALUE_W-1:0]       sample,
  output logic [fcv_pkg::PROD_W-1:0]        product
);

  logic signed [fcv_pkg::VALUE_W-1:0] kernel;
  logic signed [fcv_pkg::PROD_W-1:0]  mult;

  // The product is formed from the value entering the cell, so it matches
  // the line as it stands after this shift.
  assign mult = kernel * $signed(sample_in);

  always_ff @(posedge clk) begin
    if (kernel_we) begin
      kernel <= $signed(kernel_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (ctrl.shift) begin
      sample <= ctrl.clear ? '0 : sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      product <= tap_on ? mult : '0;
    end
  end

endmodule

// ----- rtl/fcv_sum_tree.sv -----
// ----------------------------------------------------------------------------
// fcv_sum_tree : registered adder tree
// Sums the products of all cells, with a register at every tree level.
// ----------------------------------------------------------------------------
module fcv_sum_tree (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  input  logic                                             in_last,
  input  logic [fcv_pkg::MAX_TAPS-1:0][fcv_pkg::PROD_W-1:0] products,
  output logic                                             out_valid,
  output logic                                             out_last,
  output logic [fcv_pkg::RESULT_W-1:0]                     out_sum
);

  localparam int EXT_W = fcv_pkg::RESULT_W - fcv_pkg::PROD_W;

  logic [fcv_pkg::LEAVES-1:0][fcv_pkg::RESULT_W-1:0] leaf;
  logic [fcv_pkg::RESULT_W-1:0]                      node [1:fcv_pkg::LEAVES-1];
  logic [fcv_pkg::LEVELS-1:0]                        vpipe;
  logic [fcv_pkg::LEVELS-1:0]                        lpipe;

  // Sign-extend the products; unused leaves of the padded tree are zero.
  for (genvar i = 0; i < fcv_pkg::LEAVES; i++) begin : g_leaf
    if (i < fcv_pkg::MAX_TAPS) begin : g_used
      assign leaf[i] = {{EXT_W{products[i][fcv_pkg::PROD_W-1]}}, products[i]};
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // Heap order: node 1 is the root, children of node i are 2i and 2i+1.
  for (genvar i = 1; i < fcv_pkg::LEAVES; i++) begin : g_node
    if (2 * i >= fcv_pkg::LEAVES) begin : g_bottom
      always_ff @(posedge clk) begin
        node[i] <= leaf[2*i-fcv_pkg::LEAVES] + leaf[2*i+1-fcv_pkg::LEAVES];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node[i] <= node[2*i] + node[2*i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe[0] <= in_valid;
      for (int i = 1; i < fcv_pkg::LEVELS; i++) begin
        vpipe[i] <= vpipe[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    lpipe[0] <= in_last;
    for (int i = 1; i < fcv_pkg::LEVELS; i++) begin
      lpipe[i] <= lpipe[i-1];
    end
  end

  assign out_valid = vpipe[fcv_pkg::LEVELS-1];
  assign out_last  = lpipe[fcv_pkg::LEVELS-1];
  assign out_sum   = node[1];

endmodule

// ----- rtl/fcv_out_queue.sv -----
// ----------------------------------------------------------------------------
// fcv_out_queue : result queue
// Small first-in first-out store that decouples the result channel.
// ----------------------------------------------------------------------------
module fcv_out_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fcv_pkg::res_t   push_data,
  input  logic            stall,
  output logic            valid,
  output fcv_pkg::res_t   head,
  output logic            pop
);

  fcv_pkg::res_t                mem [fcv_pkg::QUEUE_DEPTH];
  logic [fcv_pkg::QPTR_W-1:0]   wr_ptr;
  logic [fcv_pkg::QPTR_W-1:0]   rd_ptr;
  logic [fcv_pkg::QCNT_W-1:0]   count;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/fir_full_convolution.sv -----
// ----------------------------------------------------------------------------
// fir_full_convolution : streaming full linear convolution
// Direct-form FIR built from a row of tap cells, a registered adder tree
// and a result queue; produces input length plus taps minus one outputs.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload          Direction
//   -------   ------------------   --------------   ---------
//   item      item_valid/stall     fcv_pkg::item_t  into block
//   res       res_valid/stall      fcv_pkg::res_t   out of block
//   cfg       cfg_valid/ready      cfg_data[3:0]    into block
//
// One request is taken per clock while item_stall is low. A sample marked
// as last is followed by flush steps, one fewer than the tap count in use,
// in which item_stall is high while zeros are shifted through the cells; a
// held-off result channel can stretch them. A result passes through the
// product registers of the cells, one register per tree level and the
// result queue. Reset clears the delay line; tap_count returns to eight.
// The queue holds every result in flight, so a stalled result channel only
// holds off new requests once the queue and the pipeline together are full.
//
module fir_full_convolution (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  fcv_pkg::item_t                 item,
  output logic                           res_valid,
  input  logic                           res_stall,
  output fcv_pkg::res_t                  res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fcv_pkg::TAPCFG_W-1:0]   cfg_data
);

  // Configuration: tap count register, written at any time the port asks.
  logic [fcv_pkg::TAPCFG_W-1:0] tap_count;
  logic [fcv_pkg::CNT_W-1:0]    tap_ext;
  logic [fcv_pkg::CNT_W-1:0]    eff_taps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= fcv_pkg::TAP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tap_count <= cfg_data;
    end
  end

  // A tap count of zero behaves as one, and any count beyond the cells as all.
  always_comb begin
    tap_ext = fcv_pkg::CNT_W'(tap_count);
    if (tap_ext == '0) begin
      eff_taps = fcv_pkg::CNT_W'(1);
    end else if (tap_ext > fcv_pkg::CNT_W'(fcv_pkg::MAX_TAPS)) begin
      eff_taps = fcv_pkg::CNT_W'(fcv_pkg::MAX_TAPS);
    end else begin
      eff_taps = tap_ext;
    end
  end

  // Sequencer state: normal running, or flushing the tail of a block.
  fcv_pkg::state_t            state;
  fcv_pkg::state_t            state_next;
  logic [fcv_pkg::CNT_W-1:0]  remain;
  logic [fcv_pkg::CNT_W-1:0]  remain_next;

  // Credit count of results stepped but not yet delivered.
  logic [fcv_pkg::QCNT_W-1:0] pending;
  logic                       room;
  logic                       pop;

  logic                       accept;
  logic                       load;
  logic                       sample_step;
  logic                       flush_step;
  logic                       step;
  logic                       final_step;
  logic [fcv_pkg::VALUE_W-1:0] head_value;
  fcv_pkg::cell_ctrl_t        cell_ctrl;

  assign room = (pending < fcv_pkg::QCNT_W'(fcv_pkg::QUEUE_DEPTH));

  // Requests wait while zeros are pushed through the line, and whenever
  // every credit is taken.
  assign item_stall = (state != fcv_pkg::ST_RUN) || !room;

  always_comb begin
    state_next  = state;
    remain_next = remain;
    flush_step  = 1'b0;
    final_step  = 1'b0;
    head_value  = '0;

    case (state)
      fcv_pkg::ST_RUN: begin
        head_value = item.value;
        if (sample_step && item.last_sample) begin
          if (eff_taps == fcv_pkg::CNT_W'(1)) begin
            final_step = 1'b1;
          end else begin
            state_next  = fcv_pkg::ST_FLUSH;
            remain_next = eff_taps - 1'b1;
          end
        end
      end
      fcv_pkg::ST_FLUSH: begin
        flush_step = room;
        if (room) begin
          remain_next = remain - 1'b1;
          if (remain == fcv_pkg::CNT_W'(1)) begin
            final_step = 1'b1;
            state_next = fcv_pkg::ST_RUN;
          end
        end
      end
      default: begin
        state_next = fcv_pkg::ST_RUN;
      end
    endcase
  end

  assign accept      = item_valid && !item_stall;
  assign load        = accept && (item.operation == fcv_pkg::OP_LOAD);
  assign sample_step = accept && (item.operation == fcv_pkg::OP_SAMPLE);
  assign step        = sample_step || flush_step;

  // The final step of a block also empties the line, so the next block
  // starts from zeros while that step's products are already captured.
  assign cell_ctrl.shift = step;
  assign cell_ctrl.clear = final_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fcv_pkg::ST_RUN;
      remain <= '0;
    end else begin
      state  <= state_next;
      remain <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({step, pop})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  // Row of tap cells: each takes its left neighbour's sample on a step.
  logic [fcv_pkg::MAX_TAPS-1:0][fcv_pkg::VALUE_W-1:0] line;
  logic [fcv_pkg::MAX_TAPS-1:0][fcv_pkg::PROD_W-1:0]  prod_row;

  for (genvar k = 0; k < fcv_pkg::MAX_TAPS; k++) begin : g_cell
    logic                        kernel_we;
    logic                        tap_on;
    logic [fcv_pkg::VALUE_W-1:0] cell_in;

    assign kernel_we = load &&
                       (fcv_pkg::SEL_W'(item.tap_index) == fcv_pkg::SEL_W'(k));
    assign tap_on    = (fcv_pkg::CNT_W'(k) < eff_taps);

    if (k == 0) begin : g_head
      assign cell_in = head_value;
    end else begin : g_body
      assign cell_in = line[k-1];
    end

    fcv_tap_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .kernel_we   (kernel_we),
      .kernel_data (item.value),
      .tap_on      (tap_on),
      .sample_in   (cell_in),
      .sample      (line[k]),
      .product     (prod_row[k])
    );
  end

  // Tags that travel alongside the products into the tree.
  logic tag_valid;
  logic tag_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    tag_last <= final_step;
  end

  logic                          sum_valid;
  logic                          sum_last;
  logic [fcv_pkg::RESULT_W-1:0]  sum;
  fcv_pkg::res_t                 sum_res;

  fcv_sum_tree u_tree (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tag_valid),
    .in_last   (tag_last),
    .products  (prod_row),
    .out_valid (sum_valid),
    .out_last  (sum_last),
    .out_sum   (sum)
  );

  assign sum_res.result      = $signed(sum);
  assign sum_res.last_of_run = sum_last;

  fcv_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (sum_valid),
    .push_data (sum_res),
    .stall     (res_stall),
    .valid     (res_valid),
    .head      (res),
    .pop       (pop)
  );

endmodule

// ----- rtl/fcv_checker.sv -----
// ----------------------------------------------------------------------------
// fcv_checker : port-level checks of the FIR full convolution block
// Watches the request, result and configuration ports over time.
// ----------------------------------------------------------------------------
`include "fir_full_convolution_defines.svh"

module fcv_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  fcv_pkg::item_t                item,
  input  logic                          res_valid,
  input  logic                          res_stall,
  input  fcv_pkg::res_t                 res,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [fcv_pkg::TAPCFG_W-1:0]  cfg_data
);

  // Copy of the tap count as written through the port.
  logic [fcv_pkg::TAPCFG_W-1:0] tap_seen;
  logic                         last_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_seen <= fcv_pkg::TAP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tap_seen <= cfg_data;
    end
  end

  assign last_taken = item_valid && !item_stall &&
                      (item.operation == fcv_pkg::OP_SAMPLE) && item.last_sample;

  // A last sample with more than one tap must hold off requests for the flush.
  `FCV_ASSERT_NEXT(a_flush_holds, last_taken && (tap_seen >= fcv_pkg::TAPCFG_W'(2)), item_stall, "flush did not stall requests")

  // No result may be offered straight after reset.
  `FCV_ASSERT_NOW(a_empty_after_reset, $past(rst), !res_valid, "result offered after reset")

  // A stalled result stays offered and unchanged.
  `FCV_ASSERT_NEXT(a_res_held, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

endmodule

bind fir_full_convolution fcv_checker u_fcv_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_stall (item_stall),
  .item       (item),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res        (res),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_data   (cfg_data)
);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for fir_full_convolution
// Drives coefficient loads and sample blocks through the request channel,
// predicts every convolution output with a local delay line and kernel, and
// compares each result taken from the block in order. Both channels idle at
// random. The tap count is rewritten between phases, its extremes included.
// ----------------------------------------------------------------------------
module tb;

  // Covers the result latency and the longest flush after a last sample.
  localparam int DRAIN_CYCLES = 16;

  localparam logic signed [fcv_pkg::VALUE_W-1:0] VMIN = 16'sh8000;
  localparam logic signed [fcv_pkg::VALUE_W-1:0] VMAX = 16'sh7fff;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  fcv_pkg::item_t req_bus = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  fcv_pkg::res_t res_bus;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fcv_pkg::TAPCFG_W-1:0] cfg_data = '0;

  logic quiet = 1'b0;
  int stall_left = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;

  // Local copy of the filter state.
  logic signed [fcv_pkg::VALUE_W-1:0] coeff [fcv_pkg::MAX_TAPS];
  logic signed [fcv_pkg::VALUE_W-1:0] delay_line [fcv_pkg::MAX_TAPS];
  logic [fcv_pkg::TAPCFG_W-1:0] tap_setting;
  fcv_pkg::res_t pending_outputs [$];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  fir_full_convolution uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (req_bus),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res_bus),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // A register value of zero means one tap; anything above the limit is clipped.
  function automatic int unsigned taps_in_use();
    if (tap_setting == 0) return 1;
    if (tap_setting > fcv_pkg::MAX_TAPS) return fcv_pkg::MAX_TAPS;
    return tap_setting;
  endfunction

  function automatic logic signed [fcv_pkg::RESULT_W-1:0] dot_product(
      input int unsigned taps);
    longint acc;
    acc = 0;
    for (int k = 0; k < taps; k++) acc += longint'(coeff[k]) * longint'(delay_line[k]);
    return acc[fcv_pkg::RESULT_W-1:0];
  endfunction

  function automatic void shift_line(input logic signed [fcv_pkg::VALUE_W-1:0] v);
    for (int k = fcv_pkg::MAX_TAPS - 1; k > 0; k--) delay_line[k] = delay_line[k - 1];
    delay_line[0] = v;
  endfunction

  // Works out the outputs of one accepted request and queues them.
  function automatic void predict_item(input fcv_pkg::item_t it);
    int unsigned taps;
    fcv_pkg::res_t r;
    if (it.operation == fcv_pkg::OP_LOAD) begin
      coeff[it.tap_index] = it.value;
      return;
    end
    taps = taps_in_use();
    shift_line(it.value);
    r.result = dot_product(taps);
    r.last_of_run = it.last_sample && (taps == 1);
    pending_outputs.push_back(r);
    if (!it.last_sample) return;
    // The tail: zeros are shifted in until the kernel has left the block.
    for (int k = 1; k < taps; k++) begin
      shift_line('0);
      r.result = dot_product(taps);
      r.last_of_run = (k == taps - 1);
      pending_outputs.push_back(r);
    end
    foreach (delay_line[k]) delay_line[k] = '0;
  endfunction

  function automatic logic signed [fcv_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VMIN;
      1: return VMAX;
      2: return '0;
      default: return fcv_pkg::VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [fcv_pkg::TAPCFG_W-1:0] pick_tap_setting();
    case ($urandom_range(0, 7))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      3: return 4'd15;
      default: return fcv_pkg::TAPCFG_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [fcv_pkg::IDX_W-1:0] idx,
                           input logic signed [fcv_pkg::VALUE_W-1:0] v,
                           input logic last);
    fcv_pkg::item_t it;
    it.operation   = op;
    it.tap_index   = idx;
    it.value       = v;
    it.last_sample = last;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    item_valid <= 1'b1;
    req_bus <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_item(it);
    items_sent++;
  endtask

  // Loads leave no result behind, so a fixed pause follows the last output.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [fcv_pkg::TAPCFG_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tap_setting = v;
    cfg_writes++;
  endtask

  // Full-scale operands give the largest sums; a mark on a load must do nothing.
  task automatic test_extreme_products();
    for (int k = 0; k < fcv_pkg::MAX_TAPS; k++)
      send_item(fcv_pkg::OP_LOAD, k[fcv_pkg::IDX_W-1:0], VMIN, k[0]);
    for (int k = 0; k < fcv_pkg::MAX_TAPS; k++)
      send_item(fcv_pkg::OP_SAMPLE, 3'd7, VMIN, 1'b0);
    send_item(fcv_pkg::OP_SAMPLE, 3'd0, VMAX, 1'b1);
  endtask

  // Zero acts as a single tap, fifteen is clipped to the full kernel.
  task automatic test_tap_extremes();
    write_tap_count(4'd0);
    send_item(fcv_pkg::OP_SAMPLE, 3'd5, VMAX, 1'b0);
    send_item(fcv_pkg::OP_SAMPLE, 3'd2, VMIN, 1'b1);
    write_tap_count(4'd15);
    send_item(fcv_pkg::OP_SAMPLE, 3'd0, 16'sd1, 1'b1);
    write_tap_count(4'd1);
    send_item(fcv_pkg::OP_SAMPLE, 3'd7, -16'sd1, 1'b1);
  endtask

  // A new tap count and a new coefficient inside a block apply from the next sample.
  task automatic test_mid_block_changes();
    write_tap_count(4'd3);
    send_item(fcv_pkg::OP_SAMPLE, 3'd1, 16'sd1234, 1'b0);
    write_tap_count(4'd5);
    send_item(fcv_pkg::OP_LOAD, 3'd1, VMAX, 1'b1);
    send_item(fcv_pkg::OP_SAMPLE, 3'd6, -16'sd200, 1'b1);
  endtask

  // Blocks of random length and content, with loads mixed in; now and then
  // a block is left open and runs on into the next one.
  task automatic test_random_blocks(input int budget);
    int start;
    int len;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 5) == 0) write_tap_count(pick_tap_setting());
      len = $urandom_range(1, 12);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(0, 5) == 0)
          send_item(fcv_pkg::OP_LOAD, fcv_pkg::IDX_W'($urandom_range(0, 7)),
                    pick_value(), 1'($urandom_range(0, 1)));
        send_item(fcv_pkg::OP_SAMPLE, fcv_pkg::IDX_W'($urandom_range(0, 7)),
                  pick_value(), (n == len - 1) && ($urandom_range(0, 9) != 0));
      end
    end
  endtask

  task automatic test_steady_stream(input int budget);
    quiet <= 1'b1;
    test_random_blocks(budget);
  endtask

  // The receiving side holds off in bursts.
  always @(posedge clk) begin
    if (rst || quiet) begin
      res_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      res_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      res_stall <= 1'b1;
      stall_left <= $urandom_range(0, 17);
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (pending_outputs.size() == 0) begin
        $display("%0t: result with none expected, got %0d last %0b",
                 $time, res_bus.result, res_bus.last_of_run);
        errors++;
      end else begin
        if (res_bus.result !== pending_outputs[0].result) begin
          $display("%0t: result mismatch, expected %0d, got %0d",
                   $time, pending_outputs[0].result, res_bus.result);
          errors++;
        end
        if (res_bus.last_of_run !== pending_outputs[0].last_of_run) begin
          $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                   $time, pending_outputs[0].last_of_run, res_bus.last_of_run);
          errors++;
        end
        void'(pending_outputs.pop_front());
      end
    end
  end

  initial begin
    foreach (coeff[k]) coeff[k] = '0;
    foreach (delay_line[k]) delay_line[k] = '0;
    tap_setting = fcv_pkg::TAP_COUNT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_extreme_products();
    test_tap_extremes();
    test_mid_block_changes();
    test_random_blocks(290);
    test_steady_stream(60);
    wait_idle();
    $display("Run covered %0d requests, %0d outputs and %0d tap count writes.",
             items_sent, results_seen, cfg_writes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d outputs outstanding.", pending_outputs.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
